// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies; the including scope supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define ASSERT_ANY(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/jtl_pkg.sv -----
// Types, codes and character constants of the JSON token lexer.
// No dependencies; used by the lexer core, the result queue, the top level and the checker.
package jtl_pkg;

	localparam logic [2:0] KIND_BRACKET = 3'd0;
	localparam logic [2:0] KIND_COLON   = 3'd1;
	localparam logic [2:0] KIND_COMMA   = 3'd2;
	localparam logic [2:0] KIND_STRING  = 3'd3;
	localparam logic [2:0] KIND_KEYWORD = 3'd4;
	localparam logic [2:0] KIND_NUMBER  = 3'd5;
	localparam logic [2:0] KIND_END     = 3'd6;
	localparam logic [2:0] KIND_ERROR   = 3'd7;

	localparam logic [1:0] BR_LBRACE = 2'd0;
	localparam logic [1:0] BR_RBRACE = 2'd1;
	localparam logic [1:0] BR_LBRACK = 2'd2;
	localparam logic [1:0] BR_RBRACK = 2'd3;

	localparam logic [1:0] KW_TRUE  = 2'd0;
	localparam logic [1:0] KW_NULL  = 2'd1;
	localparam logic [1:0] KW_FALSE = 2'd2;

	localparam logic [2:0] ERR_NONE        = 3'd0;
	localparam logic [2:0] ERR_NO_BRACE    = 3'd1;
	localparam logic [2:0] ERR_BAD_CHAR    = 3'd2;
	localparam logic [2:0] ERR_OPEN_STRING = 3'd3;
	localparam logic [2:0] ERR_BAD_KEYWORD = 3'd4;
	localparam logic [2:0] ERR_SIGN_ALONE  = 3'd5;
	localparam logic [2:0] ERR_OVERFLOW    = 3'd6;
	localparam logic [2:0] ERR_STRAY_SPACE = 3'd7;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_VTAB    = 8'h0B;
	localparam logic [7:0] CH_FFEED   = 8'h0C;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_F       = 8'h66;
	localparam logic [7:0] CH_N       = 8'h6E;
	localparam logic [7:0] CH_T       = 8'h74;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;

	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
	localparam int LEVEL_BITS  = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [2:0]  kind;
		logic [1:0]  bracket;
		logic [1:0]  keyword;
		logic [15:0] offset;
		logic [15:0] length;
		logic [63:0] value;
		logic [2:0]  err;
		logic        last;
	} jtl_result_t;

	typedef struct packed {
		logic [1:0]  count;
		jtl_result_t first;
		jtl_result_t second;
	} jtl_push_t;

	function automatic logic [2:0] kw_len(input logic [1:0] which);
		case (which)
			KW_TRUE:  return 3'd4;
			KW_NULL:  return 3'd4;
			KW_FALSE: return 3'd5;
			default:  return 3'd0;
		endcase
	endfunction

	function automatic logic [7:0] kw_char(input logic [1:0] which, input logic [2:0] idx);
		logic [39:0] word;
		logic [39:0] sh;
		case (which)
			KW_TRUE:  word = {"true", 8'h00};
			KW_NULL:  word = {"null", 8'h00};
			default:  word = "false";
		endcase
		sh = word << {idx, 3'b000};
		return sh[39:32];
	endfunction

endpackage

// ----- hdl/jtl_core.sv -----
// Lexer core: character classes, lexer state registers and result formation.
// Depends on jtl_pkg; feeds up to two results per character to jtl_fifo.
module jtl_core #(
	parameter int OFFSET_BITS = 16,
	parameter int NUMBER_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        char_s1,
	output jtl_pkg::jtl_push_t push
);
	import jtl_pkg::*;

	localparam int OB = OFFSET_BITS;
	localparam int NB = NUMBER_BITS;
	localparam int WW = NUMBER_BITS + 4;
	localparam int CW = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;

	typedef enum logic [6:0] {
		MODE_START   = 7'b0000001,
		MODE_IDLE    = 7'b0000010,
		MODE_SPACE   = 7'b0000100,
		MODE_SIGN    = 7'b0001000,
		MODE_DIGITS  = 7'b0010000,
		MODE_STRING  = 7'b0100000,
		MODE_KEYWORD = 7'b1000000
	} mode_t;

	typedef struct packed {
		mode_t         mode;
		logic [OB-1:0] tb;
		logic [OB-1:0] run;
		logic [NB-1:0] mag;
		logic          neg;
		logic [2:0]    kwp;
		logic [1:0]    kww;
		logic          odd;
		logic          failed;
	} lex_state_t;

	localparam lex_state_t ST_RESET = '{
		mode: MODE_START, tb: '0, run: '0, mag: '0, neg: 1'b0,
		kwp: 3'd0, kww: 2'd0, odd: 1'b0, failed: 1'b0
	};

	function automatic logic [OB-1:0] inc_sat(input logic [OB-1:0] x);
		return (&x) ? x : x + 1'b1;
	endfunction

	function automatic logic [15:0] clip16(input logic [OB-1:0] x);
		logic [CW-1:0] xe;
		xe = CW'(x);
		return (xe > CW'(16'hFFFF)) ? 16'hFFFF : xe[15:0];
	endfunction

	function automatic jtl_result_t mk_res(
		input logic [2:0]    kind,
		input logic [1:0]    br,
		input logic [1:0]    kw,
		input logic [OB-1:0] off,
		input logic [OB-1:0] len,
		input logic [63:0]   val,
		input logic [2:0]    err
	);
		jtl_result_t r;
		r.kind    = kind;
		r.bracket = br;
		r.keyword = kw;
		r.offset  = clip16(off);
		r.length  = clip16(len);
		r.value   = val;
		r.err     = err;
		r.last    = 1'b0;
		return r;
	endfunction

	lex_state_t    st_q, n_st, d_st;
	logic [OB-1:0] offset_q, n_offset;

	logic          is_digit, is_plain, is_odd, is_sign;
	logic [3:0]    dval;
	logic [WW-1:0] acc, lim;
	logic          ovf;
	logic [NB-1:0] sgn_mag;
	logic [63:0]   num64;
	jtl_result_t   num_res;
	logic [2:0]    kwp_nx;
	logic          kw_match;

	logic          d_res_v, pre_v, main_v;
	jtl_result_t   d_res, pre, main;

	assign is_digit = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
	assign is_plain = (char_s1 == CH_SPACE) || (char_s1 == CH_TAB) || (char_s1 == CH_NEWLINE);
	assign is_odd   = (char_s1 == CH_VTAB) || (char_s1 == CH_FFEED) || (char_s1 == CH_CR);
	assign is_sign  = (char_s1 == CH_PLUS) || (char_s1 == CH_MINUS);
	assign dval     = char_s1[3:0];

	// overflow when ten times the magnitude plus the digit passes the signed limit
	assign acc = (WW'(st_q.mag) << 3) + (WW'(st_q.mag) << 1) + WW'(dval);
	assign lim = (WW'(1) << (NB - 1)) - WW'(!st_q.neg);
	assign ovf = acc > lim;

	assign sgn_mag = st_q.neg ? (~st_q.mag + 1'b1) : st_q.mag;
	assign num64   = 64'($signed(sgn_mag));
	assign num_res = mk_res(KIND_NUMBER, BR_LBRACE, KW_TRUE, st_q.tb, st_q.run, num64, ERR_NONE);

	assign kwp_nx   = st_q.kwp + 3'd1;
	assign kw_match = (st_q.kww <= KW_FALSE) && (st_q.kwp < kw_len(st_q.kww))
		&& (char_s1 == kw_char(st_q.kww, st_q.kwp));

	// start of a new lexeme
	always_comb begin
		d_st      = st_q;
		d_st.mode = MODE_IDLE;
		d_res_v   = 1'b0;
		d_res     = '0;
		unique case (char_s1) inside
			CH_LBRACE: begin
				d_res_v = 1'b1;
				d_res   = mk_res(KIND_BRACKET, BR_LBRACE, KW_TRUE, offset_q, OB'(1), '0, ERR_NONE);
			end
			CH_RBRACE: begin
				d_res_v = 1'b1;
				d_res   = mk_res(KIND_BRACKET, BR_RBRACE, KW_TRUE, offset_q, OB'(1), '0, ERR_NONE);
			end
			CH_LBRACK: begin
				d_res_v = 1'b1;
				d_res   = mk_res(KIND_BRACKET, BR_LBRACK, KW_TRUE, offset_q, OB'(1), '0, ERR_NONE);
			end
			CH_RBRACK: begin
				d_res_v = 1'b1;
				d_res   = mk_res(KIND_BRACKET, BR_RBRACK, KW_TRUE, offset_q, OB'(1), '0, ERR_NONE);
			end
			CH_COLON: begin
				d_res_v = 1'b1;
				d_res   = mk_res(KIND_COLON, BR_LBRACE, KW_TRUE, offset_q, OB'(1), '0, ERR_NONE);
			end
			CH_COMMA: begin
				d_res_v = 1'b1;
				d_res   = mk_res(KIND_COMMA, BR_LBRACE, KW_TRUE, offset_q, OB'(1), '0, ERR_NONE);
			end
			CH_QUOTE: begin
				d_st.mode = MODE_STRING;
				d_st.tb   = inc_sat(offset_q);
				d_st.run  = '0;
			end
			CH_T, CH_N, CH_F: begin
				d_st.mode = MODE_KEYWORD;
				d_st.tb   = offset_q;
				d_st.kwp  = 3'd1;
				d_st.kww  = (char_s1 == CH_T) ? KW_TRUE : (char_s1 == CH_N) ? KW_NULL : KW_FALSE;
			end
			CH_PLUS, CH_MINUS: begin
				d_st.mode = MODE_SIGN;
				d_st.tb   = offset_q;
				d_st.run  = OB'(1);
				d_st.neg  = (char_s1 == CH_MINUS);
				d_st.odd  = 1'b0;
			end
			CH_SPACE, CH_TAB, CH_NEWLINE, CH_VTAB, CH_FFEED, CH_CR: begin
				d_st.mode = MODE_SPACE;
				d_st.tb   = offset_q;
				d_st.run  = OB'(1);
				d_st.odd  = is_odd;
			end
			[CH_ZERO:CH_NINE]: begin
				d_st.mode = MODE_DIGITS;
				d_st.tb   = offset_q;
				d_st.run  = OB'(1);
				d_st.mag  = NB'(dval);
				d_st.neg  = 1'b0;
				d_st.odd  = 1'b0;
			end
			default: begin
				d_res_v     = 1'b1;
				d_res       = mk_res(KIND_ERROR, BR_LBRACE, KW_TRUE, offset_q, '0, '0,
					ERR_BAD_CHAR);
				d_st.failed = 1'b1;
			end
		endcase
	end

	always_comb begin
		n_st     = st_q;
		n_offset = offset_q;
		pre_v    = 1'b0;
		main_v   = 1'b0;
		pre      = '0;
		main     = '0;
		if (step) begin
			if (char_s1 == CH_NUL) begin
				if (!st_q.failed) begin
					unique case (st_q.mode)
						MODE_START: begin
							pre_v = 1'b1;
							pre   = mk_res(KIND_ERROR, BR_LBRACE, KW_TRUE, offset_q, '0, '0,
								ERR_NO_BRACE);
						end
						MODE_SPACE: begin
							pre_v = st_q.odd;
							pre   = mk_res(KIND_ERROR, BR_LBRACE, KW_TRUE, st_q.tb, '0, '0,
								ERR_STRAY_SPACE);
						end
						MODE_SIGN: begin
							pre_v = 1'b1;
							pre   = mk_res(KIND_ERROR, BR_LBRACE, KW_TRUE, st_q.tb, '0, '0,
								st_q.odd ? ERR_STRAY_SPACE : ERR_SIGN_ALONE);
						end
						MODE_DIGITS: begin
							pre_v = 1'b1;
							pre   = num_res;
						end
						MODE_STRING: begin
							pre_v = 1'b1;
							pre   = mk_res(KIND_ERROR, BR_LBRACE, KW_TRUE, st_q.tb, '0, '0,
								ERR_OPEN_STRING);
						end
						MODE_KEYWORD: begin
							pre_v = 1'b1;
							pre   = mk_res(KIND_ERROR, BR_LBRACE, KW_TRUE, st_q.tb, '0, '0,
								ERR_BAD_KEYWORD);
						end
						default: pre_v = 1'b0;
					endcase
				end
				main_v   = 1'b1;
				main     = mk_res(KIND_END, BR_LBRACE, KW_TRUE, offset_q, '0, '0, ERR_NONE);
				n_st     = ST_RESET;
				n_offset = '0;
			end else begin
				if (!st_q.failed) begin
					unique case (st_q.mode)
						MODE_START: begin
							n_st.mode = MODE_IDLE;
							main_v    = 1'b1;
							if (char_s1 == CH_LBRACE) begin
								main = mk_res(KIND_BRACKET, BR_LBRACE, KW_TRUE, offset_q, OB'(1),
									'0, ERR_NONE);
							end else begin
								main        = mk_res(KIND_ERROR, BR_LBRACE, KW_TRUE, offset_q,
									'0, '0, ERR_NO_BRACE);
								n_st.failed = 1'b1;
							end
						end
						MODE_SPACE: begin
							if (is_plain || is_odd) begin
								n_st.run = inc_sat(st_q.run);
								n_st.odd = st_q.odd | is_odd;
							end else if (is_sign) begin
								n_st.mode = MODE_SIGN;
								n_st.run  = inc_sat(st_q.run);
								n_st.neg  = (char_s1 == CH_MINUS);
							end else if (is_digit) begin
								n_st.mode = MODE_DIGITS;
								n_st.run  = inc_sat(st_q.run);
								n_st.mag  = NB'(dval);
								n_st.neg  = 1'b0;
							end else if (st_q.odd) begin
								main_v      = 1'b1;
								main        = mk_res(KIND_ERROR, BR_LBRACE, KW_TRUE, st_q.tb,
									'0, '0, ERR_STRAY_SPACE);
								n_st.failed = 1'b1;
								n_st.mode   = MODE_IDLE;
							end else begin
								n_st   = d_st;
								main_v = d_res_v;
								main   = d_res;
							end
						end
						MODE_SIGN: begin
							if (is_digit) begin
								n_st.mode = MODE_DIGITS;
								n_st.run  = inc_sat(st_q.run);
								n_st.mag  = NB'(dval);
							end else begin
								main_v      = 1'b1;
								main        = mk_res(KIND_ERROR, BR_LBRACE, KW_TRUE, st_q.tb,
									'0, '0, st_q.odd ? ERR_STRAY_SPACE : ERR_SIGN_ALONE);
								n_st.failed = 1'b1;
								n_st.mode   = MODE_IDLE;
							end
						end
						MODE_DIGITS: begin
							if (is_digit) begin
								if (ovf) begin
									main_v      = 1'b1;
									main        = mk_res(KIND_ERROR, BR_LBRACE, KW_TRUE, st_q.tb,
										'0, '0, st_q.odd ? ERR_STRAY_SPACE : ERR_OVERFLOW);
									n_st.failed = 1'b1;
									n_st.mode   = MODE_IDLE;
								end else begin
									n_st.mag = acc[NB-1:0];
									n_st.run = inc_sat(st_q.run);
								end
							end else begin
								pre_v  = 1'b1;
								pre    = num_res;
								n_st   = d_st;
								main_v = d_res_v;
								main   = d_res;
							end
						end
						MODE_STRING: begin
							if (char_s1 == CH_QUOTE) begin
								main_v    = 1'b1;
								main      = mk_res(KIND_STRING, BR_LBRACE, KW_TRUE, st_q.tb,
									st_q.run, '0, ERR_NONE);
								n_st.mode = MODE_IDLE;
							end else begin
								n_st.run = inc_sat(st_q.run);
							end
						end
						MODE_KEYWORD: begin
							if (!kw_match) begin
								main_v      = 1'b1;
								main        = mk_res(KIND_ERROR, BR_LBRACE, KW_TRUE, st_q.tb,
									'0, '0, ERR_BAD_KEYWORD);
								n_st.failed = 1'b1;
								n_st.mode   = MODE_IDLE;
							end else begin
								n_st.kwp = kwp_nx;
								if (kwp_nx == kw_len(st_q.kww)) begin
									main_v    = 1'b1;
									main      = mk_res(KIND_KEYWORD, BR_LBRACE, st_q.kww,
										st_q.tb, OB'(kw_len(st_q.kww)), '0, ERR_NONE);
									n_st.mode = MODE_IDLE;
								end
							end
						end
						default: begin
							n_st   = d_st;
							main_v = d_res_v;
							main   = d_res;
						end
					endcase
				end
				n_offset = inc_sat(offset_q);
			end
		end
	end

	// order pending result first, mark the final one
	always_comb begin
		push.count  = 2'(pre_v) + 2'(main_v);
		push.first  = pre_v ? pre : main;
		push.second = main;
		if (pre_v && main_v) begin
			push.second.last = 1'b1;
		end else begin
			push.first.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_RESET;
			offset_q <= '0;
		end else if (step) begin
			st_q     <= n_st;
			offset_q <= n_offset;
		end
	end

endmodule

// ----- hdl/jtl_fifo.sv -----
// Result queue: holds up to QUEUE_DEPTH results, takes up to two per cycle, gives at most one.
// Depends on jtl_pkg; filled by jtl_core, drained by the output channel.
module jtl_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  jtl_pkg::jtl_push_t   push,
	input  logic                 pop,
	output jtl_pkg::jtl_result_t head,
	output logic                 not_empty,
	output logic                 room
);
	import jtl_pkg::*;

	jtl_result_t           slot_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0]   wp_q, rp_q, wp_nx1;
	logic [LEVEL_BITS-1:0] level_q;
	logic                  do_pop;

	assign wp_nx1    = wp_q + PTR_BITS'(1);
	assign not_empty = (level_q != '0);
	assign do_pop    = pop && not_empty;
	assign head      = slot_q[rp_q];
	assign room      = (level_q <= LEVEL_BITS'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			slot_q[wp_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			slot_q[wp_nx1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			level_q <= '0;
		end else begin
			wp_q    <= wp_q + PTR_BITS'(push.count);
			rp_q    <= rp_q + PTR_BITS'(do_pop);
			level_q <= level_q + LEVEL_BITS'(push.count) - LEVEL_BITS'(do_pop);
		end
	end

endmodule

// ----- hdl/json_token_lexer.sv -----
// Top level of the JSON token lexer: input stage register, lexer core, result queue.
// Depends on jtl_pkg, jtl_core and jtl_fifo.
//
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------------
//  char    | char_valid / char_ready   | text_char
//  token   | token_valid / token_ready | token_kind .. error_code, last
//
// One character is taken per cycle while char_ready is high; its results enter
// the queue from the input stage. A character with two results gives two items.
// char_ready drops while a character waits in the input stage and the four-entry
// result queue has fewer than two free slots.
// arst_n clears the lexer state, queue pointers and input stage valid flag at once.
module json_token_lexer #(
	parameter int OFFSET_BITS = 16,
	parameter int NUMBER_BITS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         text_char,
	input  logic               char_valid,
	output logic               char_ready,
	output logic [2:0]         token_kind,
	output logic [1:0]         bracket_code,
	output logic [1:0]         keyword_code,
	output logic [15:0]        token_offset,
	output logic [15:0]        token_length,
	output logic signed [63:0] number_value,
	output logic [2:0]         error_code,
	output logic               last,
	output logic               token_valid,
	input  logic               token_ready
);
	import jtl_pkg::*;

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        fire, room;
	jtl_push_t   push;
	jtl_result_t head;

	assign fire       = valid_s1 && room;
	assign char_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_valid && char_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			char_s1 <= text_char;
		end
	end

	jtl_core #(
		.OFFSET_BITS(OFFSET_BITS),
		.NUMBER_BITS(NUMBER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (fire),
		.char_s1(char_s1),
		.push   (push)
	);

	jtl_fifo u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (token_ready),
		.head     (head),
		.not_empty(token_valid),
		.room     (room)
	);

	assign token_kind   = head.kind;
	assign bracket_code = head.bracket;
	assign keyword_code = head.keyword;
	assign token_offset = head.offset;
	assign token_length = head.length;
	assign number_value = $signed(head.value);
	assign error_code   = head.err;
	assign last         = head.last;

endmodule

// ----- hdl/jtl_checker.sv -----
// Port-level checks of the JSON token lexer, bound to every instance of the top level.
// Depends on jtl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jtl_checker (
	input logic               clk,
	input logic               arst_n,
	input logic [2:0]         token_kind,
	input logic [15:0]        token_length,
	input logic signed [63:0] number_value,
	input logic [2:0]         error_code,
	input logic               last,
	input logic               token_valid,
	input logic               token_ready
);
	import jtl_pkg::*;

	`ASSERT_RST(a_token_hold, token_valid && !token_ready |=> token_valid, "token item dropped")
	`ASSERT_RST(a_err_code, token_valid |-> ((token_kind == KIND_ERROR) == (error_code != ERR_NONE)), "error code mismatch")
	`ASSERT_RST(a_end_last, token_valid && (token_kind == KIND_END) |-> (last && (token_length == 16'd0)), "bad end item")
	`ASSERT_RST(a_value_zero, token_valid && (token_kind != KIND_NUMBER) |-> (number_value == 64'sd0), "value on non-number")
	`ASSERT_ANY(a_reset_idle, !arst_n |=> !token_valid, "token valid in reset")

endmodule

bind json_token_lexer jtl_checker u_checker (.*);
